// ===== design/sqlpt_pkg.sv =====
`default_nettype none

package sqlpt_pkg;

  // Default and hard cap of the leading-byte hold store
  localparam int PREFIX_DEPTH_DEF = 32;
  localparam int HOLD_MAX         = 32;

  // Character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Keyword table: CREATE, PRIMARY, INSERT, DROP (zero padded to 8)
  localparam int         NUM_KW     = 4;
  localparam logic [2:0] KW_POS_MAX = 3'd7;
  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{"C", "R", "E", "A", "T", "E", 8'h00, 8'h00},
    '{"P", "R", "I", "M", "A", "R", "Y", 8'h00},
    '{"I", "N", "S", "E", "R", "T", 8'h00, 8'h00},
    '{"D", "R", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd6, 3'd7, 3'd6, 3'd4};

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT_A,
    ST_EMIT_B,
    ST_FINAL
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic take;      // input beat accepted, update state and plan
    logic load_a;    // load the pending-space result
    logic load_b;    // load the character result
    logic load_fin;  // load a released byte or the closing result
    logic last;      // result is the last one for this beat
    logic clear;     // return text state to its reset value
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_has_a;  // offered beat would give a pending-space result
    logic in_has_b;  // offered beat would give a character result
    logic in_fin;    // offered beat ends the text
    logic plan_b;    // accepted beat has a character result
    logic plan_fin;  // accepted beat ends the text
    logic out_free;  // output register can take a result this cycle
    logic rel_more;  // held bytes remain to be released
  } stat_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

endpackage

`default_nettype wire

// ===== design/sqlpt_if.sv =====
`default_nettype none

// Input channel: one raw text byte per beat
interface sqlpt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

// Output channel: one token result per beat
interface sqlpt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_char;
  logic       char_valid;
  logic       token_done;
  logic       text_done;
  logic       prefix_overflow;
  logic       run_last;

  modport source (output valid, output token_char, output char_valid, output token_done,
                  output text_done, output prefix_overflow, output run_last, input ready);
  modport sink   (input valid, input token_char, input char_valid, input token_done,
                  input text_done, input prefix_overflow, input run_last, output ready);
endinterface

`default_nettype wire

// ===== design/sqlpt_ctrl.sv =====
`default_nettype none

module sqlpt_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  sqlpt_pkg::stat_t    stat_i,
  output sqlpt_pkg::cmd_t     cmd_o
);

  sqlpt_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sqlpt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sqlpt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.in_has_a) begin
            state_d = sqlpt_pkg::ST_EMIT_A;
          end else if (stat_i.in_has_b) begin
            state_d = sqlpt_pkg::ST_EMIT_B;
          end else if (stat_i.in_fin) begin
            state_d = sqlpt_pkg::ST_FINAL;
          end
        end
      end
      sqlpt_pkg::ST_EMIT_A: begin
        if (stat_i.out_free) begin
          if (stat_i.plan_b) begin
            state_d = sqlpt_pkg::ST_EMIT_B;
          end else if (stat_i.plan_fin) begin
            state_d = sqlpt_pkg::ST_FINAL;
          end else begin
            state_d = sqlpt_pkg::ST_IDLE;
          end
        end
      end
      sqlpt_pkg::ST_EMIT_B: begin
        if (stat_i.out_free) begin
          state_d = stat_i.plan_fin ? sqlpt_pkg::ST_FINAL : sqlpt_pkg::ST_IDLE;
        end
      end
      sqlpt_pkg::ST_FINAL: begin
        if (stat_i.out_free && !stat_i.rel_more) begin
          state_d = sqlpt_pkg::ST_IDLE;
        end
      end
      default: state_d = sqlpt_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sqlpt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      sqlpt_pkg::ST_EMIT_A: begin
        if (stat_i.out_free) begin
          cmd_o.load_a = 1'b1;
          cmd_o.last   = !stat_i.plan_b && !stat_i.plan_fin;
        end
      end
      sqlpt_pkg::ST_EMIT_B: begin
        if (stat_i.out_free) begin
          cmd_o.load_b = 1'b1;
          cmd_o.last   = !stat_i.plan_fin;
        end
      end
      sqlpt_pkg::ST_FINAL: begin
        if (stat_i.out_free) begin
          cmd_o.load_fin = 1'b1;
          cmd_o.last     = !stat_i.rel_more;
          cmd_o.clear    = !stat_i.rel_more;
        end
      end
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Only one datapath action per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.take, cmd_o.load_a, cmd_o.load_b, cmd_o.load_fin}))
    else $error("more than one datapath command at once");

  // A result is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_a || cmd_o.load_b || cmd_o.load_fin) |-> stat_i.out_free)
    else $error("result loaded while output register busy");

  // Clearing ends the text and returns to idle
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |=> (state_q == sqlpt_pkg::ST_IDLE))
    else $error("clear did not return to idle");

endmodule

`default_nettype wire

// ===== design/sqlpt_dp.sv =====
`default_nettype none

module sqlpt_dp #(
  parameter int PrefixDepth = sqlpt_pkg::PREFIX_DEPTH_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire  [7:0]        in_text_byte_i,
  input  wire               in_final_byte_i,
  input  wire               out_ready_i,
  input  sqlpt_pkg::cmd_t   cmd_i,
  output sqlpt_pkg::stat_t  stat_o,
  output logic              out_valid_o,
  output logic [7:0]        token_char_o,
  output logic              char_valid_o,
  output logic              token_done_o,
  output logic              text_done_o,
  output logic              prefix_overflow_o,
  output logic              run_last_o
);

  localparam int HoldCap = (PrefixDepth < sqlpt_pkg::HOLD_MAX) ? PrefixDepth
                                                               : sqlpt_pkg::HOLD_MAX;
  localparam int CntW    = $clog2(HoldCap + 1);
  localparam int IdxW    = (HoldCap > 1) ? $clog2(HoldCap) : 1;

  // Text state
  logic                space_pend_q, space_pend_d;
  logic                text_seen_q, text_seen_d;
  logic                seeking_q, seeking_d;
  logic [CntW-1:0]     hold_cnt_q, hold_cnt_d;
  logic                hold_ovf_q, hold_ovf_d;
  logic                tok_open_q, tok_open_d;
  logic [3:0]          kw_alive_q, kw_alive_d;
  logic [2:0]          kw_pos_q, kw_pos_d;
  logic [CntW-1:0]     rel_idx_q, rel_idx_d;
  logic [7:0]          hold_mem_q [HoldCap];
  logic [7:0]          hold_rd_q;

  // Plan of the accepted beat
  logic                a_space_q;
  logic [7:0]          b_char_q;
  logic                plan_b_q, plan_fin_q;

  // Output register
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_char_q, out_char_d;
  logic                out_cvalid_q, out_cvalid_d;
  logic                out_done_q, out_done_d;
  logic                out_tdone_q, out_tdone_d;
  logic                out_ovf_q, out_ovf_d;
  logic                out_last_q, out_last_d;

  // Beat decode
  logic                is_punct, is_space, is_letter, char_ev;
  logic                pend, seek_a, kw_match, has_a, has_b, hold_wr, hold_room;
  logic                hold_wr_en;
  logic                rel_more, out_free;
  logic [3:0]          alive_a, alive_f;
  logic [2:0]          pos_a, pos_f;

  assign is_punct  = (in_text_byte_i == sqlpt_pkg::CH_RPAREN) ||
                     (in_text_byte_i == sqlpt_pkg::CH_LPAREN) ||
                     (in_text_byte_i == sqlpt_pkg::CH_SEMI)   ||
                     (in_text_byte_i == sqlpt_pkg::CH_COMMA);
  assign is_space  = (in_text_byte_i == sqlpt_pkg::CH_SPACE);
  assign is_letter = sqlpt_pkg::is_letter(in_text_byte_i);
  assign char_ev   = !is_space;

  // Space owed before this character (punctuation pads itself)
  assign pend      = space_pend_q || (is_punct && text_seen_q);
  assign seek_a    = seeking_q && !pend;
  assign has_a     = char_ev && pend && !seeking_q && tok_open_q;
  assign has_b     = char_ev && (!seek_a || is_letter);
  assign hold_wr   = char_ev && seek_a && !is_letter;
  assign hold_room = (hold_cnt_q < CntW'(HoldCap));
  assign hold_wr_en = cmd_i.take && hold_wr && hold_room;

  // Open token equals a keyword
  always_comb begin
    kw_match = 1'b0;
    for (int k = 0; k < sqlpt_pkg::NUM_KW; k++) begin
      if (kw_alive_q[k] && (sqlpt_pkg::KW_LEN[k] == kw_pos_q)) begin
        kw_match = 1'b1;
      end
    end
  end

  // Keyword tracking: effect of the pending space, then of the character
  always_comb begin
    alive_a = kw_alive_q;
    pos_a   = kw_pos_q;
    if (has_a) begin
      if (kw_match) begin
        alive_a = '0;
      end else begin
        alive_a = '1;
        pos_a   = '0;
      end
    end
    alive_f = alive_a;
    pos_f   = pos_a;
    if (has_b) begin
      if (pos_a == sqlpt_pkg::KW_POS_MAX) begin
        alive_f = '0;
        pos_f   = sqlpt_pkg::KW_POS_MAX;
      end else begin
        for (int k = 0; k < sqlpt_pkg::NUM_KW; k++) begin
          alive_f[k] = alive_a[k] && (pos_a < sqlpt_pkg::KW_LEN[k]) &&
                       (sqlpt_pkg::KW_TEXT[k][pos_a] == in_text_byte_i);
        end
        pos_f = pos_a + 3'd1;
      end
    end
  end

  // Next text state
  always_comb begin
    space_pend_d = space_pend_q;
    text_seen_d  = text_seen_q;
    seeking_d    = seeking_q;
    hold_cnt_d   = hold_cnt_q;
    hold_ovf_d   = hold_ovf_q;
    tok_open_d   = tok_open_q;
    kw_alive_d   = kw_alive_q;
    kw_pos_d     = kw_pos_q;
    rel_idx_d    = rel_idx_q;
    if (cmd_i.clear) begin
      space_pend_d = 1'b0;
      text_seen_d  = 1'b0;
      seeking_d    = 1'b1;
      hold_cnt_d   = '0;
      hold_ovf_d   = 1'b0;
      tok_open_d   = 1'b0;
      kw_alive_d   = '1;
      kw_pos_d     = '0;
      rel_idx_d    = '0;
    end else if (cmd_i.take) begin
      kw_alive_d = alive_f;
      kw_pos_d   = pos_f;
      if (is_space) begin
        space_pend_d = space_pend_q || text_seen_q;
      end else begin
        space_pend_d = is_punct;
        text_seen_d  = 1'b1;
        seeking_d    = seek_a && !is_letter;
        if (hold_wr) begin
          if (hold_room) begin
            hold_cnt_d = hold_cnt_q + CntW'(1);
          end else begin
            hold_ovf_d = 1'b1;
          end
        end else if (seeking_q) begin
          hold_cnt_d = '0;
        end
        if (has_b) begin
          tok_open_d = 1'b1;
        end else if (has_a && !kw_match) begin
          tok_open_d = 1'b0;
        end
      end
    end else if (cmd_i.load_fin && rel_more) begin
      rel_idx_d = rel_idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_pend_q <= 1'b0;
      text_seen_q  <= 1'b0;
      seeking_q    <= 1'b1;
      hold_cnt_q   <= '0;
      hold_ovf_q   <= 1'b0;
      tok_open_q   <= 1'b0;
      kw_alive_q   <= '1;
      kw_pos_q     <= '0;
      rel_idx_q    <= '0;
    end else begin
      space_pend_q <= space_pend_d;
      text_seen_q  <= text_seen_d;
      seeking_q    <= seeking_d;
      hold_cnt_q   <= hold_cnt_d;
      hold_ovf_q   <= hold_ovf_d;
      tok_open_q   <= tok_open_d;
      kw_alive_q   <= kw_alive_d;
      kw_pos_q     <= kw_pos_d;
      rel_idx_q    <= rel_idx_d;
    end
  end

  // Hold store, written at the fill count; the entry due next is read ahead
  // so that the read data always matches the release index
  always_ff @(posedge clk_i) begin
    if (hold_wr_en) begin
      hold_mem_q[hold_cnt_q[IdxW-1:0]] <= in_text_byte_i;
    end
    if (hold_wr_en && (hold_cnt_q == rel_idx_d)) begin
      hold_rd_q <= in_text_byte_i;
    end else begin
      hold_rd_q <= hold_mem_q[rel_idx_d[IdxW-1:0]];
    end
  end

  assign rel_more = seeking_q && (rel_idx_q != hold_cnt_q);

  // Plan of the accepted beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      a_space_q  <= kw_match;
      b_char_q   <= in_text_byte_i;
      plan_b_q   <= has_b;
      plan_fin_q <= in_final_byte_i;
    end
  end

  // Output register
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_char_d   = out_char_q;
    out_cvalid_d = out_cvalid_q;
    out_done_d   = out_done_q;
    out_tdone_d  = out_tdone_q;
    out_ovf_d    = out_ovf_q;
    out_last_d   = out_last_q;
    if (cmd_i.load_a || cmd_i.load_b || cmd_i.load_fin) begin
      out_valid_d  = 1'b1;
      out_ovf_d    = hold_ovf_q;
      out_last_d   = cmd_i.last;
      out_tdone_d  = 1'b0;
      out_done_d   = 1'b0;
      out_cvalid_d = 1'b1;
      out_char_d   = sqlpt_pkg::CH_NUL;
      if (cmd_i.load_a) begin
        // absorbed keyword space, or end of token
        out_cvalid_d = a_space_q;
        out_done_d   = !a_space_q;
        out_char_d   = a_space_q ? sqlpt_pkg::CH_SPACE : sqlpt_pkg::CH_NUL;
      end else if (cmd_i.load_b) begin
        out_char_d = b_char_q;
      end else if (rel_more) begin
        out_char_d = hold_rd_q;
      end else begin
        // closing result of the text
        out_cvalid_d = 1'b0;
        out_done_d   = (seeking_q && (hold_cnt_q != '0)) || tok_open_q;
        out_tdone_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q   <= out_char_d;
    out_cvalid_q <= out_cvalid_d;
    out_done_q   <= out_done_d;
    out_tdone_q  <= out_tdone_d;
    out_ovf_q    <= out_ovf_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o       = out_valid_q;
  assign token_char_o      = out_char_q;
  assign char_valid_o      = out_cvalid_q;
  assign token_done_o      = out_done_q;
  assign text_done_o       = out_tdone_q;
  assign prefix_overflow_o = out_ovf_q;
  assign run_last_o        = out_last_q;

  // Status to the controller
  assign stat_o.in_has_a = has_a;
  assign stat_o.in_has_b = has_b;
  assign stat_o.in_fin   = in_final_byte_i;
  assign stat_o.plan_b   = plan_b_q;
  assign stat_o.plan_fin = plan_fin_q;
  assign stat_o.out_free = out_free;
  assign stat_o.rel_more = rel_more;

  // Fill count stays within the store
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_cnt_q <= CntW'(HoldCap))
    else $error("hold count beyond store depth");

  // A result without a character carries a zero byte
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_cvalid_q) |-> (out_char_q == sqlpt_pkg::CH_NUL))
    else $error("nonzero token_char without char_valid");

  // Text end restarts the search for the token start
  a_clear_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (seeking_q && (hold_cnt_q == '0) && !tok_open_q && !hold_ovf_q))
    else $error("text state not cleared at text end");

endmodule

`default_nettype wire

// ===== design/sql_text_pretokenizer_core.sv =====
// SQL text pre-tokenizer. Raw text enters one byte per beat with final_byte on
// the last byte; results leave one per beat as token characters, end-of-token
// marks and one closing result with text_done. Punctuation ( ) ; , is padded
// with spaces, space runs collapse, leading bytes before the first space or
// letter are held (up to min(PrefixDepth, 32)) and given out as one token at
// text end if no start is found, and CREATE, PRIMARY, INSERT and DROP keep
// their following space. The block takes one byte at a time: it accepts a byte
// only in idle and takes no other until every result of that byte is loaded
// into the output register, and for the final byte also every released held
// byte and the closing result. The sequencer drives a single output register,
// one result per cycle while the output does not stall.
`default_nettype none

module sql_text_pretokenizer_core #(
  parameter int PrefixDepth = sqlpt_pkg::PREFIX_DEPTH_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  sqlpt_in_if.sink     in_i,
  sqlpt_out_if.source  out_o
);

  sqlpt_pkg::cmd_t  cmd;
  sqlpt_pkg::stat_t stat;
  logic             in_ready;

  // Sequencer
  sqlpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Text state, hold store and output register
  sqlpt_dp #(
    .PrefixDepth (PrefixDepth)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_text_byte_i    (in_i.text_byte),
    .in_final_byte_i   (in_i.final_byte),
    .out_ready_i       (out_o.ready),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_o.valid),
    .token_char_o      (out_o.token_char),
    .char_valid_o      (out_o.char_valid),
    .token_done_o      (out_o.token_done),
    .text_done_o       (out_o.text_done),
    .prefix_overflow_o (out_o.prefix_overflow),
    .run_last_o        (out_o.run_last)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

// ===== sim/tb_sql_text_pretokenizer_core.sv =====
`timescale 1ns / 100ps

module tb_sql_text_pretokenizer_core;

  localparam int TEXT_BEATS   = 230;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 40;

  // Idle percentages per phase: none, sender idle, receiver stall, both
  localparam int SEND_IDLE [4] = '{0, 84, 0, 36};
  localparam int RECV_STALL[4] = '{0, 0, 84, 36};

  typedef struct packed {
    logic [7:0] token_char;
    logic       char_valid;
    logic       token_done;
    logic       text_done;
    logic       prefix_overflow;
    logic       run_last;
  } token_beat_t;

  typedef struct {
    logic [7:0] text_byte;
    bit         final_byte;
  } text_beat_t;

  // Tracks tokenizer state and the token beats still owed by the block
  class token_scoreboard;
    token_beat_t expect_q[$];
    int unsigned errors;
    int unsigned hold_cap;
    string       kw_word[4];
    bit          space_pending;
    bit          text_seen;
    bit          seeking_start;
    bit          hold_ovf;
    bit          token_open;
    logic [7:0]  held[sqlpt_pkg::HOLD_MAX];
    int unsigned held_count;
    bit [3:0]    kw_alive;
    int unsigned kw_pos;
    int unsigned beat_results;

    function new();
      hold_cap = (sqlpt_pkg::PREFIX_DEPTH_DEF < sqlpt_pkg::HOLD_MAX) ?
                 sqlpt_pkg::PREFIX_DEPTH_DEF : sqlpt_pkg::HOLD_MAX;
      kw_word  = '{"CREATE", "PRIMARY", "INSERT", "DROP"};
      errors   = 0;
      clear_text();
    endfunction

    static function bit is_alpha(logic [7:0] c);
      return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    static function bit is_punct(logic [7:0] c);
      return c inside {sqlpt_pkg::CH_RPAREN, sqlpt_pkg::CH_LPAREN, sqlpt_pkg::CH_SEMI,
                       sqlpt_pkg::CH_COMMA};
    endfunction

    function void clear_text();
      space_pending = 1'b0;
      text_seen     = 1'b0;
      seeking_start = 1'b1;
      held_count    = 0;
      hold_ovf      = 1'b0;
      token_open    = 1'b0;
      kw_alive      = 4'hF;
      kw_pos        = 0;
    endfunction

    function void put(logic [7:0] ch, bit cv, bit done, bit tdone);
      token_beat_t r;
      r.token_char      = cv ? ch : sqlpt_pkg::CH_NUL;
      r.char_valid      = cv;
      r.token_done      = done;
      r.text_done       = tdone;
      r.prefix_overflow = hold_ovf;
      r.run_last        = 1'b0;
      expect_q.push_back(r);
      beat_results++;
    endfunction

    // Advance keyword matching by one token byte
    function void feed_kw(logic [7:0] ch);
      if (kw_pos >= sqlpt_pkg::KW_POS_MAX) begin
        kw_alive = 4'h0;
        kw_pos   = sqlpt_pkg::KW_POS_MAX;
        return;
      end
      for (int k = 0; k < 4; k++) begin
        if (kw_alive[k] && (kw_pos >= kw_word[k].len() || kw_word[k][kw_pos] != ch)) begin
          kw_alive[k] = 1'b0;
        end
      end
      kw_pos++;
    endfunction

    function bit kw_hit();
      for (int k = 0; k < 4; k++) begin
        if (kw_alive[k] && kw_word[k].len() == kw_pos) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void mark_space();
      if (text_seen) space_pending = 1'b1;
    endfunction

    // A non-space byte: settle any pending space first, then hold or emit
    function void take_char(logic [7:0] ch);
      if (space_pending) begin
        space_pending = 1'b0;
        if (seeking_start) begin
          seeking_start = 1'b0;
          held_count    = 0;
        end else if (token_open) begin
          if (kw_hit()) begin
            put(sqlpt_pkg::CH_SPACE, 1'b1, 1'b0, 1'b0);
            kw_alive = 4'h0;
          end else begin
            put(sqlpt_pkg::CH_NUL, 1'b0, 1'b1, 1'b0);
            token_open = 1'b0;
            kw_alive   = 4'hF;
            kw_pos     = 0;
          end
        end
      end
      text_seen = 1'b1;
      if (seeking_start) begin
        if (is_alpha(ch)) begin
          seeking_start = 1'b0;
          held_count    = 0;
        end else begin
          if (held_count < hold_cap) begin
            held[held_count] = ch;
            held_count++;
          end else begin
            hold_ovf = 1'b1;
          end
          return;
        end
      end
      put(ch, 1'b1, 1'b0, 1'b0);
      token_open = 1'b1;
      feed_kw(ch);
    endfunction

    // Accepted input beat: queue every token beat it causes
    function void note_text_byte(logic [7:0] b, bit fin);
      beat_results = 0;
      if (is_punct(b)) begin
        mark_space();
        take_char(b);
        mark_space();
      end else if (b == sqlpt_pkg::CH_SPACE) begin
        mark_space();
      end else begin
        take_char(b);
      end
      if (fin) begin
        space_pending = 1'b0;
        if (seeking_start && held_count > 0) begin
          for (int i = 0; i < held_count; i++) put(held[i], 1'b1, 1'b0, 1'b0);
          put(sqlpt_pkg::CH_NUL, 1'b0, 1'b1, 1'b1);
        end else begin
          put(sqlpt_pkg::CH_NUL, 1'b0, token_open, 1'b1);
        end
        clear_text();
      end
      if (beat_results > 0) begin
        expect_q[expect_q.size() - 1].run_last = 1'b1;
      end
    endfunction

    static function string show(token_beat_t r);
      return $sformatf("char=%02h cv=%b done=%b tdone=%b ovf=%b last=%b", r.token_char,
                       r.char_valid, r.token_done, r.text_done, r.prefix_overflow, r.run_last);
    endfunction

    function void check_result(token_beat_t got);
      token_beat_t want;
      if (expect_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected token beat: expected none, actual %s", $time, show(got));
        return;
      end
      want = expect_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: token beat mismatch: expected %s, actual %s", $time, show(want),
                   show(got));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   cycle_count;

  token_scoreboard sb;
  text_beat_t      stim_q[$];

  string vocab[20] = '{"CREATE", "PRIMARY", "INSERT", "DROP", "TABLE", "KEY", "INTO", "t1",
                       "x", "drop", "CREATEX", "PRIMAR", "DROPS", "(", ")", ",", ";",
                       "Insert", "42", "a_b"};

  sqlpt_in_if  in_if();
  sqlpt_out_if out_if();

  sql_text_pretokenizer_core #(
    .PrefixDepth(sqlpt_pkg::PREFIX_DEPTH_DEF)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stimulus building
  function void add_byte(logic [7:0] b);
    text_beat_t t;
    t.text_byte  = b;
    t.final_byte = 1'b0;
    stim_q.push_back(t);
  endfunction

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function void finish_text();
    stim_q[stim_q.size() - 1].final_byte = 1'b1;
  endfunction

  // Byte that stays in the leading hold: no letter, space or punctuation
  function logic [7:0] prefix_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (token_scoreboard::is_alpha(b) || b == sqlpt_pkg::CH_SPACE ||
           token_scoreboard::is_punct(b));
    return b;
  endfunction

  function void add_random_text();
    int kind;
    int n;
    kind = $urandom_range(9);
    if (kind <= 5) begin
      // statement-like text: words, keywords and punctuation
      repeat ($urandom_range(2)) add_byte(sqlpt_pkg::CH_SPACE);
      repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0) add_byte(prefix_byte());
      n = $urandom_range(1, 6);
      for (int w = 0; w < n; w++) begin
        add_text(vocab[$urandom_range(19)]);
        if (w < n - 1) repeat ($urandom_range(3)) add_byte(sqlpt_pkg::CH_SPACE);
      end
      if ($urandom_range(3) == 0) add_byte(sqlpt_pkg::CH_SPACE);
    end else if (kind <= 7) begin
      // long leading hold, often around the store size
      n = ($urandom_range(2) == 0) ? $urandom_range(1, 12) : $urandom_range(30, 36);
      repeat (n) add_byte(prefix_byte());
      if ($urandom_range(1)) add_text(vocab[$urandom_range(19)]);
    end else begin
      // raw noise
      n = $urandom_range(1, 10);
      repeat (n) add_byte(($urandom_range(7) == 0) ? sqlpt_pkg::CH_SPACE
                                                    : 8'($urandom_range(255)));
    end
    finish_text();
  endfunction

  // Offer one beat, with an optional idle gap first
  task automatic send_beat(input logic [7:0] b, input bit fin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid      <= 1'b1;
    in_if.text_byte  <= b;
    in_if.final_byte <= fin;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_text_byte(b, fin);
  endtask

  // Result side: check accepted beats, then pick ready for the next cycle
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        sb.check_result('{out_if.token_char, out_if.char_valid, out_if.token_done,
                          out_if.text_done, out_if.prefix_overflow, out_if.run_last});
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[sql_text_pretokenizer_core] ERROR");
    $finish;
  end

  initial begin
    int phase;
    sb               = new();
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.text_byte  <= sqlpt_pkg::CH_NUL;
    in_if.final_byte <= 1'b0;

    // Directed: keyword space, punctuation, released hold with extreme bytes,
    // blank text, hold dropped by a space
    add_text(" DROP  t");
    finish_text();
    add_text("a(B),c;");
    finish_text();
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text("#");
    finish_text();
    add_text("  ");
    finish_text();
    add_text("9 x");
    finish_text();
    while (stim_q.size() < TEXT_BEATS) add_random_text();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < stim_q.size(); i++) begin
      phase          = (i * 4) / stim_q.size();
      send_idle_pct  = SEND_IDLE[phase];
      recv_stall_pct = RECV_STALL[phase];
      send_beat(stim_q[i].text_byte, stim_q[i].final_byte);
    end
    in_if.valid <= 1'b0;

    while (sb.expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.expect_q.size() == 0) begin
      $display("[sql_text_pretokenizer_core] OK");
    end else begin
      $display("[sql_text_pretokenizer_core] ERROR");
    end
    $finish;
  end

endmodule
